/* hdl/stable_priority_queue_defines.svh */
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

/* hdl/spq_pkg.sv */
// Shared constants and types for the priority queue.
package spq_pkg;

  localparam int DEFAULT_DEPTH          = 16;
  localparam int DEFAULT_DATA_WIDTH     = 32;
  localparam int DEFAULT_PRIORITY_WIDTH = 16;

  localparam int STATUS_WIDTH = 2;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic push;
    logic pop;
  } ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// One slot of the sorted register row: holds an entry and shifts with its neighbours.
module spq_cell #(
  parameter int DATA_WIDTH     = spq_pkg::DEFAULT_DATA_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEFAULT_PRIORITY_WIDTH
) (
  input  logic                      clk_i,
  input  spq_pkg::ctrl_t            ctrl_i,
  input  logic                      valid_i,
  input  logic [DATA_WIDTH-1:0]     new_data_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic                      left_keep_i,
  input  logic [DATA_WIDTH-1:0]     left_data_i,
  input  logic [PRIORITY_WIDTH-1:0] left_prio_i,
  input  logic [DATA_WIDTH-1:0]     right_data_i,
  input  logic [PRIORITY_WIDTH-1:0] right_prio_i,
  output logic                      keep_o,
  output logic [DATA_WIDTH-1:0]     data_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o
);
  import spq_pkg::*;

  logic [DATA_WIDTH-1:0]     data_q, data_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;

  // An entry of equal or higher priority stays ahead of a new one.
  assign keep_o = valid_i && (prio_q >= new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.push) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          data_d = new_data_i;
          prio_d = new_prio_i;
        end else begin
          data_d = left_data_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.pop) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

/* hdl/spq_out_stage.sv */
// Two-entry registered result stage with a skid slot.
module spq_out_stage #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  logic             out_valid_q;
  logic             skid_valid_q;
  logic [WIDTH-1:0] out_q;
  logic [WIDTH-1:0] skid_q;
  logic             in_fire;
  logic             out_free;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // A waiting result in the skid slot always leaves before a newer one.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/stable_priority_queue.sv */
// Top level of the bounded, arrival-stable priority queue.
`include "stable_priority_queue_defines.svh"

// Bounded priority queue built as a row of DEPTH cells kept in descending
// priority order. Each accepted transaction is either an insert (tuser 0) or a
// remove of the front entry (tuser 1) and yields exactly one result transaction
// carrying a status, the removed word and the entry count after the item.
// Entries of equal priority leave in the order they arrived. A remove from an
// empty queue reports the empty status and an insert to a full queue is
// discarded with the full status; the stored entries are then unchanged. Every
// cell compares the new priority and shifts in the same cycle, so one item is
// taken per clock while the input is not stalled, and its result is registered.
// A two-entry output stage lets the next item be taken while one result waits;
// the input stalls only while both are held. No clearing pass is needed after reset.
module stable_priority_queue #(
  parameter int DEPTH          = spq_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH     = spq_pkg::DEFAULT_DATA_WIDTH,
  parameter int PRIORITY_WIDTH = spq_pkg::DEFAULT_PRIORITY_WIDTH,
  localparam int CountWidth    = $clog2(DEPTH + 1),
  localparam int InDataWidth   = ((DATA_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
  localparam int OutDataWidth  = ((DATA_WIDTH + CountWidth + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // item_data, item_priority, zero padding
  input  logic [InDataWidth-1:0]  s_axis_tdata_i,
  // opcode
  input  logic                    s_axis_tuser_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // removed_data, entry_count, zero padding
  output logic [OutDataWidth-1:0] m_axis_tdata_o,
  // status
  output logic [spq_pkg::STATUS_WIDTH-1:0] m_axis_tuser_o
);
  import spq_pkg::*;

  localparam int ResWidth = STATUS_WIDTH + DATA_WIDTH + CountWidth;

  logic                      in_fire;
  logic [DATA_WIDTH-1:0]     new_data;
  logic [PRIORITY_WIDTH-1:0] new_prio;
  logic                      is_full;
  logic                      no_entries;
  ctrl_t                     ctrl;
  logic [CountWidth-1:0]     count_q, count_d;
  logic [STATUS_WIDTH-1:0]   res_status;
  logic [DATA_WIDTH-1:0]     res_removed;
  logic [ResWidth-1:0]       res;
  logic [ResWidth-1:0]       out_res;

  logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];
  logic                      cell_keep [DEPTH];

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign new_data   = s_axis_tdata_i[DATA_WIDTH-1:0];
  assign new_prio   = s_axis_tdata_i[DATA_WIDTH +: PRIORITY_WIDTH];
  assign is_full    = (count_q == CountWidth'(DEPTH));
  assign no_entries = (count_q == '0);

  assign ctrl.push = in_fire && (s_axis_tuser_i == OP_INSERT) && !is_full;
  assign ctrl.pop  = in_fire && (s_axis_tuser_i == OP_REMOVE) && !no_entries;

  always_comb begin
    count_d     = count_q;
    res_status  = STATUS_OK;
    res_removed = '0;
    if (s_axis_tuser_i == OP_INSERT) begin
      if (is_full) begin
        res_status = STATUS_FULL;
      end else begin
        count_d = count_q + CountWidth'(1);
      end
    end else begin
      if (no_entries) begin
        res_status = STATUS_EMPTY;
      end else begin
        count_d     = count_q - CountWidth'(1);
        res_removed = cell_data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_fire) begin
      count_q <= count_d;
    end
  end

  // Slots below the count hold entries; the rest are free.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_keep;
    logic [DATA_WIDTH-1:0]     left_data;
    logic [PRIORITY_WIDTH-1:0] left_prio;
    logic [DATA_WIDTH-1:0]     right_data;
    logic [PRIORITY_WIDTH-1:0] right_prio;

    if (i == 0) begin : g_front
      assign left_keep = 1'b1;
      assign left_data = new_data;
      assign left_prio = new_prio;
    end else begin : g_inner_left
      assign left_keep = cell_keep[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CountWidth'(i)),
      .new_data_i   (new_data),
      .new_prio_i   (new_prio),
      .left_keep_i  (left_keep),
      .left_data_i  (left_data),
      .left_prio_i  (left_prio),
      .right_data_i (right_data),
      .right_prio_i (right_prio),
      .keep_o       (cell_keep[i]),
      .data_o       (cell_data[i]),
      .prio_o       (cell_prio[i])
    );
  end

  assign res = {count_d, res_removed, res_status};

  spq_out_stage #(
    .WIDTH (ResWidth)
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tuser_o = out_res[STATUS_WIDTH-1:0];
  assign m_axis_tdata_o = OutDataWidth'(out_res[ResWidth-1:STATUS_WIDTH]);

  `SPQ_ASSERT_NOW(a_count_bounded, clk_i, rst_ni, 1'b1, count_q <= CountWidth'(DEPTH))
  `SPQ_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, ctrl.push, count_q == $past(count_q) + CountWidth'(1))
  `SPQ_ASSERT_NEXT(a_pop_shrinks, clk_i, rst_ni, ctrl.pop, count_q == $past(count_q) - CountWidth'(1))
  `SPQ_ASSERT_NOW(a_front_sorted, clk_i, rst_ni, count_q >= CountWidth'(2), cell_prio[0] >= cell_prio[1])

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the stable priority queue stream block.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int Depth        = DEFAULT_DEPTH;
  localparam int DataWidth    = DEFAULT_DATA_WIDTH;
  localparam int PrioWidth    = DEFAULT_PRIORITY_WIDTH;
  localparam int CountWidth   = $clog2(Depth + 1);
  localparam int InDataWidth  = ((DataWidth + PrioWidth + 7) / 8) * 8;
  localparam int OutDataWidth = ((DataWidth + CountWidth + 7) / 8) * 8;
  localparam int RandomItems  = 380;
  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 8;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [DataWidth-1:0]    removed_data;
    logic [CountWidth-1:0]   entry_count;
  } queue_result_t;

  // Keeps its own sorted copy of the queue and the results still awaited.
  class prio_queue_scoreboard;
    logic [PrioWidth-1:0] prio_row[Depth];
    logic [DataWidth-1:0] word_row[Depth];
    int unsigned          fill;
    queue_result_t        awaited_results[$];
    int unsigned          errors;
    int unsigned          inserts;
    int unsigned          removes;
    int unsigned          empty_hits;
    int unsigned          full_hits;
    int unsigned          results_seen;

    function new();
      fill         = 0;
      errors       = 0;
      inserts      = 0;
      removes      = 0;
      empty_hits   = 0;
      full_hits    = 0;
      results_seen = 0;
    endfunction

    function void note_item(logic op, logic [DataWidth-1:0] word, logic [PrioWidth-1:0] prio);
      queue_result_t res;
      int unsigned   pos;
      int unsigned   k;
      res.status       = STATUS_OK;
      res.removed_data = '0;
      if (op == OP_INSERT) begin
        inserts++;
        if (fill >= Depth) begin
          res.status = STATUS_FULL;
          full_hits++;
        end else begin
          // The new entry goes behind every entry of equal or higher priority.
          pos = 0;
          while (pos < fill && prio_row[pos] >= prio) pos++;
          for (k = fill; k > pos; k--) begin
            prio_row[k] = prio_row[k-1];
            word_row[k] = word_row[k-1];
          end
          prio_row[pos] = prio;
          word_row[pos] = word;
          fill++;
        end
      end else begin
        removes++;
        if (fill == 0) begin
          res.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          res.removed_data = word_row[0];
          for (k = 1; k < fill; k++) begin
            prio_row[k-1] = prio_row[k];
            word_row[k-1] = word_row[k];
          end
          fill--;
        end
      end
      res.entry_count = fill[CountWidth-1:0];
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_WIDTH-1:0] status,
                               logic [DataWidth-1:0] removed_data,
                               logic [CountWidth-1:0] entry_count);
      queue_result_t exp;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transaction arrived with none expected");
        errors++;
        return;
      end
      exp = awaited_results.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (removed_data !== exp.removed_data) begin
        $error("removed_data: expected %h, actual %h", exp.removed_data, removed_data);
        errors++;
      end
      if (entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [InDataWidth-1:0]        s_axis_tdata  = '0;
  logic                          s_axis_tuser  = OP_INSERT;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]       m_axis_tdata;
  logic [STATUS_WIDTH-1:0]       m_axis_tuser;

  prio_queue_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned random_sent = 0;
  int unsigned drain_pauses = 0;

  stable_priority_queue DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("stable_priority_queue test failed");
      $finish;
    end
  end

  // Result side: checks each transaction and stalls in stretches of varying density.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata[DataWidth-1:0],
                      m_axis_tdata[DataWidth+CountWidth-1:DataWidth]);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Presents one item and holds it until the handshake completes; valid stays high.
  task automatic send_item(input logic op, input logic [DataWidth-1:0] word,
                           input logic [PrioWidth-1:0] prio);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {prio, word};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, word, prio);
  endtask

  task automatic idle_cycles(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Sends an item, then either carries on with the burst or leaves a gap.
  task automatic drive_item(input logic op, input logic [DataWidth-1:0] word,
                            input logic [PrioWidth-1:0] prio);
    send_item(op, word, prio);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      idle_cycles($urandom_range(1, 6));
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_until_drained();
    idle_cycles(1);
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    drain_pauses++;
  endtask

  // Priorities are drawn so that ties are common and both extremes turn up often.
  function automatic logic [PrioWidth-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PrioWidth'($urandom_range(0, 16'hFFFF));
      1: return PrioWidth'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return PrioWidth'(16'h8000 + $urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int unsigned insert_pct;
    int unsigned phase_len;
    logic        op;

    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty removal, extreme fields, ties at both ends of the range.
    drive_item(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    drive_item(OP_INSERT, 32'h0000_0000, 16'h0000);
    drive_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    drive_item(OP_INSERT, 32'hA5A5_A5A5, 16'h8000);
    drive_item(OP_INSERT, 32'h5A5A_5A5A, 16'h8000);
    drive_item(OP_INSERT, 32'h1234_5678, 16'h0000);
    drive_item(OP_INSERT, 32'hCAFE_0001, 16'hFFFF);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_INSERT, 32'h0BAD_F00D, 16'h8000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 16'h0000);
    wait_until_drained();

    // Random phases alternate filling, draining and mixed traffic so that the
    // queue regularly reaches both its full and its empty state.
    while (random_sent < RandomItems) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 90;
        1: insert_pct = 15;
        2: insert_pct = 50;
        default: insert_pct = 100;
      endcase
      phase_len = $urandom_range(10, 40);
      repeat (phase_len) begin
        op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
        drive_item(op, DataWidth'($urandom()), pick_priority());
        random_sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_until_drained();
    end

    wait_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d inserts and %0d removes, %0d results checked",
             sb.inserts, sb.removes, sb.results_seen);
    $display("full refusals %0d, empty removals %0d, drain pauses %0d",
             sb.full_hits, sb.empty_hits, drain_pauses);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("stable_priority_queue test passed");
    end else begin
      $display("stable_priority_queue test failed");
    end
    $finish;
  end

endmodule
